// ===== src/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console cell writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED = 2'd0,
    CFG_COLUMNS = 2'd1,
    CFG_ROWS    = 2'd2
  } cfg_idx_t;

  localparam logic [7:0] ATTR_WHITE   = 8'h0F;
  localparam logic [7:0] CH_NUL       = 8'd0;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic [7:0] RST_COLUMNS = 8'd80;
  localparam logic [7:0] RST_ROWS    = 8'd25;

  typedef struct packed {
    logic       enabled;
    logic [7:0] columns;
    logic [7:0] rows;
  } cfg_t;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
  } cursor_t;

  typedef struct packed {
    logic        cell_write;
    logic [15:0] cell_index;
    logic [15:0] cell_value;
    logic        scroll_up;
  } result_t;

endpackage

// ===== src/tcw_config_regs.sv =====
// ----------------------------------------------------------------------------
// tcw_config_regs
// Configuration register file: enable, screen columns and rows.
// ----------------------------------------------------------------------------
module tcw_config_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data,
  output tcw_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled <= 1'b1;
      cfg.columns <= tcw_pkg::RST_COLUMNS;
      cfg.rows    <= tcw_pkg::RST_ROWS;
    end else if (cfg_we) begin
      case (cfg_index)
        tcw_pkg::CFG_ENABLED: cfg.enabled <= cfg_data[0];
        tcw_pkg::CFG_COLUMNS: cfg.columns <= cfg_data;
        tcw_pkg::CFG_ROWS:    cfg.rows    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/tcw_cursor_step.sv =====
// ----------------------------------------------------------------------------
// tcw_cursor_step
// One character against the cursor: cell write, wrap, scroll, next cursor.
// ----------------------------------------------------------------------------
module tcw_cursor_step (
  input  tcw_pkg::cfg_t    cfg,
  input  tcw_pkg::cursor_t cursor,
  input  logic [7:0]       char_code,
  output tcw_pkg::cursor_t cursor_next,
  output tcw_pkg::result_t result
);

  logic        active;
  logic        is_bs;
  logic [7:0]  idx_col;
  logic [15:0] cell_addr;
  logic [8:0]  col_n;
  logic [8:0]  row_n;

  assign active  = cfg.enabled && (char_code != tcw_pkg::CH_NUL);
  assign is_bs   = (char_code == tcw_pkg::CH_BACKSPACE);
  assign idx_col = is_bs ? (cursor.col - 8'd1) : cursor.col;
  assign cell_addr = ({8'd0, cursor.row} * {8'd0, cfg.columns}) + {8'd0, idx_col};

  always_comb begin
    result = '0;
    col_n  = {1'b0, cursor.col};
    row_n  = {1'b0, cursor.row};
    if (active) begin
      case (char_code)
        tcw_pkg::CH_NEWLINE: begin
          col_n = '0;
          row_n = row_n + 9'd1;
        end
        tcw_pkg::CH_RETURN: begin
          col_n = '0;
        end
        tcw_pkg::CH_BACKSPACE: begin
          if (cursor.col != 8'd0) begin
            col_n             = {1'b0, idx_col};
            result.cell_write = 1'b1;
            result.cell_index = cell_addr;
            result.cell_value = {tcw_pkg::ATTR_WHITE, tcw_pkg::CH_SPACE};
          end
        end
        default: begin
          col_n             = col_n + 9'd1;
          result.cell_write = 1'b1;
          result.cell_index = cell_addr;
          result.cell_value = {tcw_pkg::ATTR_WHITE, char_code};
        end
      endcase
      if (col_n >= {1'b0, cfg.columns}) begin
        col_n = '0;
        row_n = row_n + 9'd1;
      end
      if (row_n >= {1'b0, cfg.rows}) begin
        result.scroll_up = 1'b1;
        row_n = (cfg.rows != 8'd0) ? {1'b0, cfg.rows - 8'd1} : 9'd0;
      end
    end
    cursor_next.col = col_n[7:0];
    cursor_next.row = row_n[7:0];
  end

endmodule

// ===== src/text_console_cell_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Character stream in, screen cell writes and scroll requests out.
// ----------------------------------------------------------------------------
// One result beat per character beat, one beat per cycle sustained while
// the master side is ready. A beat is captured in the input register; the
// cursor update and the row*columns+column multiply-add then run against
// the cursor registers and load the output register. Backpressure on the
// master side holds both stages; the input register keeps taking beats
// while a result waits as long as it is empty. Configuration must be written
// only while no beats are in flight.
module text_console_cell_writer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] char_code
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata,   // [15:0] cell_index, [31:16] cell_value
  output logic [1:0]                    m_tuser    // [0] cell_write, [1] scroll_up
);

  tcw_pkg::cfg_t    cfg;
  tcw_pkg::cursor_t cursor;
  tcw_pkg::cursor_t cursor_next;
  tcw_pkg::result_t result_next;
  tcw_pkg::result_t result;

  logic       in_valid;
  logic [7:0] in_char;
  logic       out_free;
  logic       advance;

  tcw_config_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tcw_cursor_step u_step (
    .cfg         (cfg),
    .cursor      (cursor),
    .char_code   (in_char),
    .cursor_next (cursor_next),
    .result      (result_next)
  );

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
      cursor   <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (out_free) begin
        m_tvalid <= in_valid;
      end
      if (advance) begin
        cursor <= cursor_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  assign m_tdata = {result.cell_value, result.cell_index};
  assign m_tuser = {result.scroll_up, result.cell_write};

endmodule

// ===== tb/sv/text_console_cell_writer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_cell_writer_tb
// Self-checking bench for the text console cell writer.
// A short table of directed characters and register writes comes first, then
// random screen geometries with random character streams. Each result beat is
// checked against the table or a cursor predictor, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module text_console_cell_writer_tb;

  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned DIR_N        = 22;

  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_COMB} sink_mode_t;

  typedef struct packed {
    logic              is_cfg;
    tcw_pkg::cfg_idx_t reg_sel;
    logic [7:0]        data;
    logic              typed;
    tcw_pkg::result_t  want;
  } dir_row_t;

  localparam tcw_pkg::result_t NO_CELL = '0;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  tcw_pkg::cfg_idx_t cfg_index = tcw_pkg::CFG_ENABLED;
  logic [7:0]        cfg_data = 8'd0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = 8'd0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [31:0]       m_tdata;
  logic [1:0]        m_tuser;

  tcw_pkg::cfg_t    screen_cfg;
  tcw_pkg::cursor_t cursor;
  tcw_pkg::result_t cell_q[$];
  int unsigned      mismatch_cnt = 0;
  int unsigned      burst_left = 0;
  int unsigned      gap_max = 4;
  int unsigned      rand_beats = 0;
  bit               hold_req = 0;

  dir_row_t dir_tab [DIR_N] = '{
    '{1'b0, tcw_pkg::CFG_ENABLED, 8'h41, 1'b1, '{1'b1, 16'd0, 16'h0F41, 1'b0}},
    '{1'b0, tcw_pkg::CFG_ENABLED, tcw_pkg::CH_NUL, 1'b1, NO_CELL},
    '{1'b0, tcw_pkg::CFG_ENABLED, 8'hFF, 1'b1, '{1'b1, 16'd1, 16'h0FFF, 1'b0}},
    '{1'b0, tcw_pkg::CFG_ENABLED, tcw_pkg::CH_BACKSPACE, 1'b1,
      '{1'b1, 16'd1, 16'h0F20, 1'b0}},
    '{1'b0, tcw_pkg::CFG_ENABLED, tcw_pkg::CH_BACKSPACE, 1'b1,
      '{1'b1, 16'd0, 16'h0F20, 1'b0}},
    '{1'b0, tcw_pkg::CFG_ENABLED, tcw_pkg::CH_BACKSPACE, 1'b1, NO_CELL},
    '{1'b0, tcw_pkg::CFG_ENABLED, 8'h78,                 1'b0, NO_CELL},
    '{1'b0, tcw_pkg::CFG_ENABLED, tcw_pkg::CH_RETURN,    1'b0, NO_CELL},
    '{1'b0, tcw_pkg::CFG_ENABLED, tcw_pkg::CH_NEWLINE,   1'b0, NO_CELL},
    '{1'b1, tcw_pkg::CFG_ENABLED, 8'd0,                  1'b0, NO_CELL},
    '{1'b0, tcw_pkg::CFG_ENABLED, 8'h51,                 1'b1, NO_CELL},
    '{1'b0, tcw_pkg::CFG_ENABLED, tcw_pkg::CH_NEWLINE,   1'b1, NO_CELL},
    '{1'b1, tcw_pkg::CFG_ENABLED, 8'd1,                  1'b0, NO_CELL},
    '{1'b1, tcw_pkg::CFG_COLUMNS, 8'd1,                  1'b0, NO_CELL},
    '{1'b1, tcw_pkg::CFG_ROWS,    8'd1,                  1'b0, NO_CELL},
    // cursor now sits below a one-row screen
    '{1'b0, tcw_pkg::CFG_ENABLED, 8'h61,                 1'b0, NO_CELL},
    '{1'b0, tcw_pkg::CFG_ENABLED, 8'h62,                 1'b0, NO_CELL},
    '{1'b0, tcw_pkg::CFG_ENABLED, tcw_pkg::CH_NEWLINE,   1'b0, NO_CELL},
    '{1'b1, tcw_pkg::CFG_COLUMNS, 8'd255,                1'b0, NO_CELL},
    '{1'b1, tcw_pkg::CFG_ROWS,    8'd255,                1'b0, NO_CELL},
    '{1'b0, tcw_pkg::CFG_ENABLED, 8'h7F,                 1'b0, NO_CELL},
    '{1'b0, tcw_pkg::CFG_ENABLED, tcw_pkg::CH_RETURN,    1'b0, NO_CELL}
  };

  text_console_cell_writer DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // cursor update and cell write for one character
  function automatic tcw_pkg::result_t cursor_step(logic [7:0] ch);
    tcw_pkg::result_t res;
    int unsigned      col;
    int unsigned      row;
    res = '0;
    col = cursor.col;
    row = cursor.row;
    if (screen_cfg.enabled && ch != tcw_pkg::CH_NUL) begin
      case (ch)
        tcw_pkg::CH_NEWLINE: begin
          col = 0;
          row = row + 1;
        end
        tcw_pkg::CH_RETURN: begin
          col = 0;
        end
        tcw_pkg::CH_BACKSPACE: begin
          if (col > 0) begin
            col = col - 1;
            res.cell_write = 1'b1;
            res.cell_index = 16'(row * screen_cfg.columns + col);
            res.cell_value = {tcw_pkg::ATTR_WHITE, tcw_pkg::CH_SPACE};
          end
        end
        default: begin
          res.cell_write = 1'b1;
          res.cell_index = 16'(row * screen_cfg.columns + col);
          res.cell_value = {tcw_pkg::ATTR_WHITE, ch};
          col = col + 1;
        end
      endcase
      if (col >= screen_cfg.columns) begin
        col = 0;
        row = row + 1;
      end
      if (row >= screen_cfg.rows) begin
        res.scroll_up = 1'b1;
        row = (screen_cfg.rows > 0) ? screen_cfg.rows - 1 : 0;
      end
      cursor.col = 8'(col);
      cursor.row = 8'(row);
    end
    return res;
  endfunction

  function automatic logic [7:0] rand_char(int unsigned ctrl_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll >= ctrl_pct) return 8'($urandom_range(0, 255));
    case (roll % 5)
      0: return tcw_pkg::CH_NEWLINE;
      1: return tcw_pkg::CH_RETURN;
      2, 3: return tcw_pkg::CH_BACKSPACE;
      default: return tcw_pkg::CH_NUL;
    endcase
  endfunction

  // one character beat; leaves s_tvalid high at the accepting edge
  task automatic put_char(input logic [7:0] ch, input logic typed,
                          input tcw_pkg::result_t want);
    int unsigned      gap;
    tcw_pkg::result_t res;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    res = cursor_step(ch);
    cell_q.push_back(typed ? want : res);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (cell_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input tcw_pkg::cfg_idx_t sel, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    case (sel)
      tcw_pkg::CFG_ENABLED: screen_cfg.enabled = val[0];
      tcw_pkg::CFG_COLUMNS: screen_cfg.columns = val;
      default:              screen_cfg.rows    = val;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_geometry(input logic en, input logic [7:0] cols, input logic [7:0] rws,
                              input int unsigned beats, input int unsigned ctrl_pct);
    settle();
    write_reg(tcw_pkg::CFG_ENABLED, {7'd0, en});
    write_reg(tcw_pkg::CFG_COLUMNS, cols);
    write_reg(tcw_pkg::CFG_ROWS, rws);
    end_writes();
    repeat (beats) put_char(rand_char(ctrl_pct), 1'b0, NO_CELL);
    rand_beats += beats;
  endtask

  function automatic logic [7:0] pick_extent();
    case ($urandom_range(0, 3))
      0: return 8'd1;
      1: return 8'd255;
      2: return 8'($urandom_range(1, 8));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // sink pacing
  initial begin : sink_pacing
    sink_mode_t  mode;
    int unsigned pace_cyc;
    int unsigned hold_left;
    mode = SINK_OPEN;
    pace_cyc = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      pace_cyc++;
      if (pace_cyc % 97 == 0) mode = sink_mode_t'($urandom_range(0, 2));
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          SINK_OPEN: m_tready <= 1'b1;
          SINK_COIN: m_tready <= 1'($urandom_range(0, 1));
          default:   m_tready <= (pace_cyc % 4) != 0;
        endcase
      end
    end
  end

  // result checker
  initial begin : cell_check
    tcw_pkg::result_t got;
    tcw_pkg::result_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = '{m_tuser[0], m_tdata[15:0], m_tdata[31:16], m_tuser[1]};
        if (cell_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t unexpected beat: wr=%0b idx=%0d val=%h scr=%0b", $realtime,
                   got.cell_write, got.cell_index, got.cell_value, got.scroll_up);
        end else begin
          want = cell_q.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            $display("%0t mismatch: expected wr=%0b idx=%0d val=%h scr=%0b", $realtime,
                     want.cell_write, want.cell_index, want.cell_value, want.scroll_up);
            $display("%0t            actual   wr=%0b idx=%0d val=%h scr=%0b", $realtime,
                     got.cell_write, got.cell_index, got.cell_value, got.scroll_up);
          end
        end
      end
    end
  end

  initial begin : watchdog
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    screen_cfg = '{1'b1, tcw_pkg::RST_COLUMNS, tcw_pkg::RST_ROWS};
    cursor = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int unsigned i = 0; i < DIR_N; i++) begin
      if (dir_tab[i].is_cfg) begin
        settle();
        write_reg(dir_tab[i].reg_sel, dir_tab[i].data);
        end_writes();
      end else begin
        put_char(dir_tab[i].data, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // long sink hold-off with the source streaming back to back
    settle();
    gap_max = 0;
    hold_req = 1;
    repeat (40) put_char(rand_char(30), 1'b0, NO_CELL);
    rand_beats += 40;

    // climb to deep rows on a one-column screen, then widen for large indexes
    gap_max = 3;
    run_geometry(1'b1, 8'd1, 8'd255, 200, 8);
    run_geometry(1'b1, 8'd255, 8'd255, 50, 10);

    while (rand_beats < 360) begin
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      run_geometry($urandom_range(0, 5) != 0, pick_extent(), pick_extent(),
                   $urandom_range(15, 40), 30);
    end

    settle();
    if (mismatch_cnt == 0 && cell_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tcw_pkg.sv
src/tcw_config_regs.sv
src/tcw_cursor_step.sv
src/text_console_cell_writer.sv
tb/sv/text_console_cell_writer_tb.sv
